/* src/csp_pkg.sv */
// Shared types, codes and field limits for the cron schedule matcher.
package csp_pkg;

    typedef enum logic [1:0] {
        ACT_CLEAR = 2'd0,
        ACT_CHAR  = 2'd1,
        ACT_CHECK = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_START  = 3'd1,
        PH_HIGH   = 3'd2,
        PH_STEP   = 3'd3,
        PH_FIELD  = 3'd4,
        PH_CLOSED = 3'd5
    } t_phase;

    localparam int QDEPTH = 2;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] char_code;
        logic [5:0] minute;
        logic [4:0] hour;
        logic [4:0] day_of_month;
        logic [3:0] month;
        logic [2:0] weekday;
    } t_item;

    typedef struct packed {
        logic       due;
        logic [2:0] fields_parsed;
    } t_result;

    function automatic logic [6:0] field_lo(input logic [2:0] f);
        case (f)
            3'd2, 3'd3: field_lo = 7'd1;
            default:    field_lo = 7'd0;
        endcase
    endfunction

    function automatic logic [6:0] field_hi(input logic [2:0] f);
        case (f)
            3'd0:    field_hi = 7'd59;
            3'd1:    field_hi = 7'd23;
            3'd2:    field_hi = 7'd31;
            3'd3:    field_hi = 7'd12;
            default: field_hi = 7'd6;
        endcase
    endfunction

endpackage

/* src/csp_queue.sv */
// Two-entry queue of accepted words between the front and the back.
module csp_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  csp_pkg::t_item  i_data,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output csp_pkg::t_item  o_data
);
    import csp_pkg::*;

    t_item      r_mem [QDEPTH];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'(QDEPTH));
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push && !o_full) begin
                r_mem[r_wp] <= i_data;
                r_wp        <= ~r_wp;
            end
            if (i_pop && !o_empty) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push && !o_full) - 2'(i_pop && !o_empty);
        end
    end
endmodule

/* src/csp_engine.sv */
// Parser and matcher: classifies each word, walks mask fills one bit a cycle.
module csp_engine (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  csp_pkg::t_item    i_item,
    output logic              o_take,
    output logic              o_res_valid,
    output csp_pkg::t_result  o_res,
    input  logic              i_res_pop
);
    import csp_pkg::*;

    logic [59:0] r_min_mask;
    logic [23:0] r_hr_mask;
    logic [31:0] r_day_mask;
    logic [12:0] r_mon_mask;
    logic [6:0]  r_wd_mask;
    logic [2:0]  r_fidx;
    logic [6:0]  r_lo, r_hi, r_acc;
    t_phase      r_ph;
    logic        r_have, r_stepd, r_abort;

    // fill walker
    logic        r_fill;
    logic [2:0]  r_ff;
    logic [6:0]  r_fx, r_fhi, r_fstr;
    // one-entry result register
    logic        r_rv;
    t_result     r_res;

    // pending follow-up fill, started after the walker finishes
    logic        r_pend;
    logic [6:0]  r_plo, r_phi;
    logic [2:0]  r_pf;

    logic        n_fill;
    logic [2:0]  n_ff;
    logic [6:0]  n_fx, n_fhi, n_fstr;
    logic        n_pend;
    logic [6:0]  n_plo, n_phi;
    logic [2:0]  n_pf;
    logic [2:0]  n_fidx;
    logic [6:0]  n_lo, n_hi, n_acc;
    t_phase      n_ph;
    logic        n_have, n_stepd, n_abort;
    logic        n_due;
    logic [10:0] v_mul;
    logic [7:0]  c;
    logic        is_digit;

    // take a new word when no fill is pending or running and the result slot is free or being read this cycle
    assign o_take      = i_valid && !r_fill && !r_pend && (!r_rv || i_res_pop);
    assign o_res_valid = r_rv;
    assign o_res       = r_res;

    // check that a fill of [lo,hi] may start: element seen, valid field, lo <= hi, within the field limits
    function automatic logic fill_ok(input logic [2:0] f, input logic [6:0] lo,
                                     input logic [6:0] hi, input logic have);
        fill_ok = have && (f <= 3'd4) && (lo >= field_lo(f)) && (hi <= field_hi(f))
                  && (lo <= hi);
    endfunction

    always_comb begin
        n_fill = r_fill; n_ff = r_ff; n_fx = r_fx; n_fhi = r_fhi; n_fstr = r_fstr;
        n_pend = r_pend; n_plo = r_plo; n_phi = r_phi; n_pf = r_pf;
        n_fidx = r_fidx; n_lo = r_lo; n_hi = r_hi; n_acc = r_acc; n_ph = r_ph;
        n_have = r_have; n_stepd = r_stepd; n_abort = r_abort;
        n_due = 1'b0;
        c = i_item.char_code;
        is_digit = (c >= 8'd48) && (c <= 8'd57);
        v_mul = 11'(r_acc) * 11'd10 + 11'(c - 8'd48);

        if (r_fill) begin
            if (8'(r_fx) + 8'(r_fstr) > 8'(r_fhi)) n_fill = 1'b0;
            else n_fx = r_fx + r_fstr;
        end else if (r_pend) begin
            n_pend = 1'b0;
            if (fill_ok(r_pf, r_plo, r_phi, 1'b1)) begin
                n_fill = 1'b1; n_ff = r_pf; n_fx = r_plo; n_fhi = r_phi; n_fstr = 7'd1;
            end
        end else if (o_take) begin
            case (i_item.action)
                ACT_CLEAR: begin
                    n_fidx = '0; n_lo = '0; n_hi = '0; n_acc = '0; n_ph = PH_IDLE;
                    n_have = 1'b0; n_stepd = 1'b0; n_abort = 1'b0;
                end
                ACT_CHECK: begin
                    n_due = r_min_mask[i_item.minute] && r_hr_mask[i_item.hour]
                            && r_day_mask[i_item.day_of_month]
                            && r_mon_mask[i_item.month] && r_wd_mask[i_item.weekday];
                    if (i_item.minute > 6'd59 || i_item.hour > 5'd23
                        || i_item.month > 4'd12 || i_item.weekday > 3'd6)
                        n_due = 1'b0;
                end
                ACT_CHAR: begin
                    if (r_ph == PH_CLOSED) begin
                        n_ph = r_ph;
                    end else if (r_fidx >= 3'd5) begin
                        if (c == 8'd10) n_ph = PH_CLOSED;
                    end else if (c == 8'd32 || c == 8'd10) begin
                        if (r_ph != PH_IDLE) begin
                            if (!r_abort) begin
                                // finish pending number, then element fill
                                logic [6:0] lo, hi;
                                logic       hv, st;
                                lo = r_lo; hi = r_hi; hv = r_have; st = r_stepd;
                                if (r_ph == PH_START) begin
                                    lo = r_acc; hi = r_acc; hv = 1'b1;
                                end else if (r_ph == PH_HIGH) begin
                                    hi = r_acc;
                                    if (r_acc < r_lo) begin lo = r_acc; hi = r_lo; end
                                end else if (r_ph == PH_STEP) begin
                                    st = 1'b1;
                                    if (fill_ok(r_fidx, lo, hi, hv)) begin
                                        n_fill = 1'b1; n_ff = r_fidx; n_fx = lo;
                                        n_fhi = hi;
                                        n_fstr = (r_acc == 7'd0) ? 7'd1 : r_acc;
                                    end
                                end
                                if (!st && fill_ok(r_fidx, lo, hi, hv)) begin
                                    n_fill = 1'b1; n_ff = r_fidx; n_fx = lo; n_fhi = hi;
                                    n_fstr = 7'd1;
                                end
                                n_lo = lo; n_hi = hi;
                            end
                            n_fidx = r_fidx + 3'd1;
                            n_ph = PH_IDLE; n_have = 1'b0; n_stepd = 1'b0;
                            n_abort = 1'b0; n_acc = '0;
                        end
                        if (c == 8'd10) n_ph = PH_CLOSED;
                    end else begin
                        t_phase ph;
                        logic [6:0] lo, hi;
                        logic       hv, st;
                        ph = (r_ph == PH_IDLE) ? PH_FIELD : r_ph;
                        lo = r_lo; hi = r_hi; hv = r_have; st = r_stepd;
                        n_ph = ph;
                        if (!r_abort) begin
                            if (is_digit) begin
                                if (ph == PH_FIELD) begin
                                    n_ph = PH_START; n_acc = 7'(c - 8'd48);
                                end else begin
                                    n_acc = (v_mul > 11'd127) ? 7'd127 : v_mul[6:0];
                                end
                            end else begin
                                if (ph == PH_START) begin
                                    lo = r_acc; hi = r_acc; hv = 1'b1;
                                end else if (ph == PH_HIGH) begin
                                    hi = r_acc;
                                    if (r_acc < r_lo) begin lo = r_acc; hi = r_lo; end
                                end else if (ph == PH_STEP) begin
                                    st = 1'b1;
                                    if (fill_ok(r_fidx, lo, hi, hv)) begin
                                        n_fill = 1'b1; n_ff = r_fidx; n_fx = lo;
                                        n_fhi = hi;
                                        n_fstr = (r_acc == 7'd0) ? 7'd1 : r_acc;
                                    end
                                end
                                if (ph == PH_START || ph == PH_HIGH || ph == PH_STEP)
                                    ph = PH_FIELD;
                                n_ph = ph;
                                if (c == 8'd42) begin
                                    lo = field_lo(r_fidx); hi = field_hi(r_fidx);
                                    hv = 1'b1;
                                end else if (c == 8'd45) begin
                                    if (!hv) n_abort = 1'b1;
                                    else begin n_ph = PH_HIGH; n_acc = '0; end
                                end else if (c == 8'd47) begin
                                    n_ph = PH_STEP; n_acc = '0;
                                end else if (c == 8'd44) begin
                                    if (!st && fill_ok(r_fidx, lo, hi, hv)) begin
                                        // step fill already running means st set
                                        n_fill = 1'b1; n_ff = r_fidx; n_fx = lo;
                                        n_fhi = hi; n_fstr = 7'd1;
                                    end
                                    hv = 1'b0; st = 1'b0;
                                end
                                n_lo = lo; n_hi = hi; n_have = hv; n_stepd = st;
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_mask <= '0; r_hr_mask <= '0; r_day_mask <= '0;
            r_mon_mask <= '0; r_wd_mask <= '0;
            r_fidx <= '0; r_lo <= '0; r_hi <= '0; r_acc <= '0; r_ph <= PH_IDLE;
            r_have <= 1'b0; r_stepd <= 1'b0; r_abort <= 1'b0;
            r_fill <= 1'b0; r_pend <= 1'b0; r_rv <= 1'b0;
            r_ff <= '0; r_fx <= '0; r_fhi <= '0; r_fstr <= 7'd1;
            r_plo <= '0; r_phi <= '0; r_pf <= '0;
        end else begin
            r_fill <= n_fill; r_ff <= n_ff; r_fx <= n_fx; r_fhi <= n_fhi;
            r_fstr <= n_fstr; r_pend <= n_pend; r_plo <= n_plo; r_phi <= n_phi;
            r_pf <= n_pf;
            r_fidx <= n_fidx; r_lo <= n_lo; r_hi <= n_hi; r_acc <= n_acc;
            r_ph <= n_ph; r_have <= n_have; r_stepd <= n_stepd; r_abort <= n_abort;
            // mark one bit of the walk per cycle
            if (r_fill) begin
                case (r_ff)
                    3'd0: r_min_mask[r_fx[5:0]] <= 1'b1;
                    3'd1: r_hr_mask[r_fx[4:0]]  <= 1'b1;
                    3'd2: r_day_mask[r_fx[4:0]] <= 1'b1;
                    3'd3: r_mon_mask[r_fx[3:0]] <= 1'b1;
                    default: r_wd_mask[r_fx[2:0]] <= 1'b1;
                endcase
            end
            if (o_take && i_item.action == ACT_CLEAR) begin
                r_min_mask <= '0; r_hr_mask <= '0; r_day_mask <= '0;
                r_mon_mask <= '0; r_wd_mask <= '0;
            end
            if (o_take) begin
                r_rv  <= 1'b1;
                r_res <= '{due: n_due, fields_parsed: n_fidx};
            end else if (i_res_pop) begin
                r_rv <= 1'b0;
            end
        end
    end
endmodule

/* src/cron_schedule_parse_and_match.sv */
// Cron line parser and time matcher, top level.
//
// Words enter through a queue port: raise push while full is low.
// Action 0 clears the masks, action 1 feeds one character of the cron
// line, action 2 checks a time. Every word gives one result word, read
// through empty/pop in order; o_due and o_fields_parsed show the
// oldest result while empty is low.
// A word waits in a two-entry queue, then the engine handles it.
// A character that closes an element walks the mask one bit a cycle,
// during which the engine takes no new word.
// The result sits in a one-entry output register; a word passes the
// queue and then that register before its result is on the ports.
// With pop held high, one word a cycle flows when no walk is running.
// While the receiver holds pop low the engine stops after one result,
// and the input queue fills, then full rises.
// Synchronous reset clears all masks, the parse state, the input queue and the result register.
module cron_schedule_parse_and_match (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [1:0] i_action,
    input  logic [7:0] i_char_code,
    input  logic [5:0] i_minute,
    input  logic [4:0] i_hour,
    input  logic [4:0] i_day_of_month,
    input  logic [3:0] i_month,
    input  logic [2:0] i_weekday,
    output logic       empty,
    input  logic       pop,
    output logic       o_due,
    output logic [2:0] o_fields_parsed
);
    import csp_pkg::*;

    t_item   w_in, w_q;
    t_result w_res;
    logic    w_qempty, w_take, w_rv;

    assign w_in = '{action: i_action, char_code: i_char_code, minute: i_minute,
                    hour: i_hour, day_of_month: i_day_of_month, month: i_month,
                    weekday: i_weekday};

    csp_queue u_queue (
        .i_clk, .i_rst_n, .i_push(push), .i_data(w_in), .o_full(full),
        .i_pop(w_take), .o_empty(w_qempty), .o_data(w_q)
    );

    csp_engine u_engine (
        .i_clk, .i_rst_n, .i_valid(!w_qempty), .i_item(w_q), .o_take(w_take),
        .o_res_valid(w_rv), .o_res(w_res), .i_res_pop(pop)
    );

    assign empty           = !w_rv;
    assign o_due           = w_res.due;
    assign o_fields_parsed = w_res.fields_parsed;
endmodule

/* src/csp_checker.sv */
// Port-level checks for the cron matcher, bound to the top level.
module csp_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       push,
    input logic       full,
    input logic       empty,
    input logic       pop,
    input logic       o_due,
    input logic [2:0] o_fields_parsed
);
    a_fields_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> o_fields_parsed <= 3'd5) else $error("field count out of range");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_due))) else $error("result lost");
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty && !full) else $error("not empty after reset");
endmodule

bind cron_schedule_parse_and_match csp_checker u_csp_checker (.*);

/* bench/tb.sv */
// Self-checking bench for the cron schedule parser and time matcher.
module tb;
    import csp_pkg::*;

    // Holds the parse state and masks, predicts each result word in order.
    class cron_scoreboard;
        bit [59:0] min_m;
        bit [23:0] hr_m;
        bit [31:0] day_m;
        bit [12:0] mon_m;
        bit [6:0]  wd_m;
        int unsigned fidx, lo, hi, acc;
        t_phase phase;
        bit started, stepped, aborted;
        t_result pending[$];
        int errors;
        int checked;
        int dues;

        function void clear_state();
            min_m = '0; hr_m = '0; day_m = '0; mon_m = '0; wd_m = '0;
            fidx = 0; lo = 0; hi = 0; acc = 0;
            phase = PH_IDLE;
            started = 0; stepped = 0; aborted = 0;
        endfunction

        function int unsigned lim_lo(int unsigned f);
            return (f == 2 || f == 3) ? 1 : 0;
        endfunction

        function int unsigned lim_hi(int unsigned f);
            case (f)
                0: return 59;
                1: return 23;
                2: return 31;
                3: return 12;
                default: return 6;
            endcase
        endfunction

        function void set_bit(int unsigned x);
            case (fidx)
                0: min_m[x] = 1'b1;
                1: hr_m[x] = 1'b1;
                2: day_m[x] = 1'b1;
                3: mon_m[x] = 1'b1;
                default: wd_m[x] = 1'b1;
            endcase
        endfunction

        function void fill(int unsigned stride);
            int unsigned x;
            if (fidx > 4 || !started) return;
            if (lo < lim_lo(fidx) || hi > lim_hi(fidx)) return;
            if (stride == 0) stride = 1;
            for (x = lo; x <= hi; x += stride) set_bit(x);
        endfunction

        function void close_number();
            int unsigned t;
            if (phase == PH_START) begin
                lo = acc; hi = acc; started = 1;
            end else if (phase == PH_HIGH) begin
                hi = acc;
                if (hi < lo) begin
                    t = lo; lo = hi; hi = t;
                end
            end else if (phase == PH_STEP) begin
                fill(acc);
                stepped = 1;
            end
            if (phase inside {PH_START, PH_HIGH, PH_STEP}) phase = PH_FIELD;
        endfunction

        function void close_field();
            if (phase == PH_IDLE) return;
            if (!aborted) begin
                close_number();
                if (!stepped) fill(1);
            end
            fidx++;
            phase = PH_IDLE;
            started = 0; stepped = 0; aborted = 0; acc = 0;
        endfunction

        function void take_char(int unsigned c);
            int unsigned v;
            if (phase == PH_CLOSED) return;
            if (fidx >= 5) begin
                if (c == 10) phase = PH_CLOSED;
                return;
            end
            if (c == 32 || c == 10) begin
                close_field();
                if (c == 10) phase = PH_CLOSED;
                return;
            end
            if (phase == PH_IDLE) phase = PH_FIELD;
            if (aborted) return;
            if (c >= 48 && c <= 57) begin
                if (phase == PH_FIELD) begin
                    phase = PH_START;
                    acc = c - 48;
                end else begin
                    v = acc * 10 + (c - 48);
                    acc = v > 127 ? 127 : v;
                end
                return;
            end
            close_number();
            if (c == 42) begin
                lo = lim_lo(fidx); hi = lim_hi(fidx); started = 1;
            end else if (c == 45) begin
                if (!started) aborted = 1;
                else begin
                    phase = PH_HIGH; acc = 0;
                end
            end else if (c == 47) begin
                phase = PH_STEP; acc = 0;
            end else if (c == 44) begin
                if (!stepped) fill(1);
                started = 0; stepped = 0;
            end
        endfunction

        function void note_word(t_item it);
            t_result r;
            bit [63:0] m0, m1, m2, m3, m4;
            r.due = 1'b0;
            case (t_action'(it.action))
                ACT_CLEAR: clear_state();
                ACT_CHAR:  take_char(32'(it.char_code));
                ACT_CHECK: begin
                    m0 = 64'(min_m); m1 = 64'(hr_m); m2 = 64'(day_m);
                    m3 = 64'(mon_m); m4 = 64'(wd_m);
                    r.due = m0[it.minute] & m1[it.hour] & m2[it.day_of_month]
                          & m3[it.month] & m4[it.weekday];
                end
                default: ;
            endcase
            r.fields_parsed = fidx[2:0];
            pending.push_back(r);
        endfunction

        function void check_word(logic d, logic [2:0] fp);
            t_result e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result due=%0b fields=%0d", $time, d, fp);
                errors++;
                return;
            end
            e = pending.pop_front();
            checked++;
            if (e.due) dues++;
            if (d !== e.due) begin
                $display("%0t: due expected %0b actual %0b", $time, e.due, d);
                errors++;
            end
            if (fp !== e.fields_parsed) begin
                $display("%0t: fields_parsed expected %0d actual %0d",
                         $time, e.fields_parsed, fp);
                errors++;
            end
        endfunction
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       push = 1'b0;
    logic       full;
    logic [1:0] i_action = '0;
    logic [7:0] i_char_code = '0;
    logic [5:0] i_minute = '0;
    logic [4:0] i_hour = '0;
    logic [4:0] i_day_of_month = '0;
    logic [3:0] i_month = '0;
    logic [2:0] i_weekday = '0;
    logic       empty;
    logic       pop = 1'b0;
    logic       o_due;
    logic [2:0] o_fields_parsed;

    cron_schedule_parse_and_match dut (.*);

    cron_scoreboard sb = new();
    int cycles = 0;
    bit hold_rx = 0;
    bit stall_rx = 0;
    bit words_done = 0;
    int words_sent = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 1500000) begin
            $display("cron_schedule_parse_and_match verification failed");
            $finish;
        end
    end

    // Sample accepted words and popped results at the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (push && !full) sb.note_word('{i_action, i_char_code, i_minute,
                i_hour, i_day_of_month, i_month, i_weekday});
            if (pop && !empty) sb.check_word(o_due, o_fields_parsed);
        end
    end

    function int unsigned gap_len();
        if ($urandom_range(0, 99) < 3) return $urandom_range(20, 80);
        if ($urandom_range(0, 99) < 40) return 0;
        return $urandom_range(1, 3);
    endfunction

    // Receiver: random pop, with long hold-offs on request and at random.
    always @(negedge i_clk) begin
        if (hold_rx || stall_rx) pop <= 1'b0;
        else pop <= ($urandom_range(0, 99) < 70);
    end

    initial begin
        int unsigned n;
        forever begin
            @(negedge i_clk);
            if (!hold_rx && i_rst_n && $urandom_range(0, 99) < 2) begin
                n = $urandom_range(10, 60);
                stall_rx = 1;
                repeat (n) @(negedge i_clk);
                stall_rx = 0;
            end
        end
    end

    task automatic send_word(t_action a, int unsigned c, int unsigned mi,
                             int unsigned h, int unsigned d, int unsigned mo,
                             int unsigned w, bit no_gap = 0);
        int unsigned g;
        g = no_gap ? 0 : gap_len();
        if (g > 0) begin
            push <= 1'b0;
            repeat (g) @(negedge i_clk);
        end
        push <= 1'b1;
        i_action <= a; i_char_code <= 8'(c); i_minute <= 6'(mi); i_hour <= 5'(h);
        i_day_of_month <= 5'(d); i_month <= 4'(mo); i_weekday <= 3'(w);
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        words_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_char(int unsigned c, bit no_gap = 0);
        send_word(ACT_CHAR, c, $urandom, $urandom, $urandom, $urandom, $urandom,
                  no_gap);
    endtask

    task automatic send_line(string s);
        int i;
        send_word(ACT_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        for (i = 0; i < s.len(); i++) send_char(32'(s[i]));
    endtask

    task automatic send_check(bit in_range);
        if (in_range)
            send_word(ACT_CHECK, $urandom, $urandom_range(0, 59), $urandom_range(0, 23),
                      $urandom_range(1, 31), $urandom_range(1, 12), $urandom_range(0, 6));
        else
            send_word(ACT_CHECK, $urandom, $urandom, $urandom, $urandom, $urandom,
                      $urandom);
    endtask

    task automatic drain();
        push <= 1'b0;
        while (sb.pending.size() != 0) @(negedge i_clk);
    endtask

    // Element text: well-formed with random content, now and then broken.
    function string rand_elem(int unsigned f);
        string s;
        int unsigned k, top;
        top = (f == 0) ? 59 : (f == 1) ? 23 : (f == 2) ? 31 : (f == 3) ? 12 : 6;
        k = $urandom_range(0, 9);
        if (k < 2) s = "*";
        else if (k < 5) s = $sformatf("%0d", $urandom_range(0, top + 1));
        else if (k < 8) s = $sformatf("%0d-%0d", $urandom_range(0, top), $urandom_range(0, top + 2));
        else if (k == 8) s = $sformatf("%0d", $urandom_range(0, 999));
        else s = (($urandom & 1) != 0) ? "-3" : "5-";
        if ($urandom_range(0, 3) == 0) begin
            k = $urandom_range(0, 6);
            s = {s, "/"};
            if (k != 0) s = {s, $sformatf("%0d", $urandom_range(0, 2 * top))};
        end
        return s;
    endfunction

    function string rand_line();
        string s;
        int unsigned f, e, ne;
        s = "";
        for (f = 0; f < 5; f++) begin
            ne = $urandom_range(1, 3);
            for (e = 0; e < ne; e++) s = {s, (e > 0) ? "," : "", rand_elem(f)};
            s = {s, ($urandom_range(0, 5) == 0) ? "  " : " "};
        end
        if ($urandom_range(0, 1) != 0) s = {s, "run x"};
        return {s, "\n"};
    endfunction

    string directed[$] = '{
        "* * * * *\n",
        "0 0 1 1 0\n",
        "59 23 31 12 6\n",
        "0-59/1 5-3 */7 12-1/0 1,3,5 cmd\n",
        "*/ -5 3- 1-/2 60\n",
        "a1b2 x 0,,4 200 7\n",
        "10/3 4/ 0 13 0\n",
        "5 5\n5 5 5\n"
    };

    initial begin
        int i, j, k;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed[i]) begin
            send_line(directed[i]);
            send_check(1);
            send_word(ACT_CHECK, 0, 59, 23, 31, 12, 6);
            send_word(ACT_CHECK, 0, 63, 31, 0, 15, 7);
        end
        send_word(ACT_NONE, 255, 63, 31, 31, 15, 7);
        send_word(ACT_CHAR, 0, 0, 0, 0, 0, 0);
        send_word(ACT_CHAR, 255, 0, 0, 0, 0, 0);
        drain();

        // Receiver held off while the sender keeps pushing.
        hold_rx = 1;
        fork
            begin
                repeat (200) @(negedge i_clk);
                hold_rx = 0;
            end
            begin
                send_line("* * * * *\n");
                for (i = 0; i < 12; i++) send_check(1);
            end
        join
        drain();

        while (words_sent < 1150) begin
            k = $urandom_range(0, 9);
            if (k < 7) begin
                string s;
                s = rand_line();
                send_word(ACT_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom,
                          $urandom);
                for (j = 0; j < s.len(); j++)
                    send_char(32'(s[j]), $urandom_range(0, 3) == 0);
                for (j = 0; j < 4; j++) send_check($urandom_range(0, 7) != 0);
            end else if (k < 9) begin
                for (j = 0; j < 6; j++)
                    send_word(t_action'($urandom_range(0, 3)), $urandom, $urandom,
                              $urandom, $urandom, $urandom, $urandom);
            end else begin
                drain();
            end
        end
        drain();
        repeat (100) @(negedge i_clk);

        $display("Sent %0d words, checked %0d results, %0d of them due.",
                 words_sent, sb.checked, sb.dues);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("cron_schedule_parse_and_match verification clean");
        else
            $display("cron_schedule_parse_and_match verification failed");
        $finish;
    end

endmodule
